// ===== design/i2cts_pkg.sv =====
// Package: types, codes and helpers shared by the I2C transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none
package i2cts_pkg;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_REGREAD = 2'd2;
  localparam logic [1:0] FUNC_STATUS  = 2'd3;

  // bus engine status codes, already divided by eight
  localparam logic [4:0] ST_BUS_ERR    = 5'd0;   // 0x00
  localparam logic [4:0] ST_START      = 5'd1;   // 0x08
  localparam logic [4:0] ST_RSTART     = 5'd2;   // 0x10
  localparam logic [4:0] ST_SLAW_NACK  = 5'd4;   // 0x20
  localparam logic [4:0] ST_TXDAT_NACK = 5'd6;   // 0x30
  localparam logic [4:0] ST_ARB_LOST   = 5'd7;   // 0x38
  localparam logic [4:0] ST_SLAR_NACK  = 5'd9;   // 0x48
  localparam logic [4:0] ST_RXDAT_NACK = 5'd11;  // 0x58

  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_W_SLA  = 4'd1,
    PH_W_DATA = 4'd2,
    PH_W_FIN  = 4'd3,
    PH_R_SLA  = 4'd4,
    PH_R_RECV = 4'd5,
    PH_R_FIN  = 4'd6,
    PH_G_SLAW = 4'd7,
    PH_G_REG  = 4'd8,
    PH_G_RS   = 4'd9,
    PH_G_SLAR = 4'd10,
    PH_G_RECV = 4'd11,
    PH_G_FIN  = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RACK  = 3'd3,
    CMD_RNACK = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] target_address;
    logic [7:0] write_byte;
    logic [4:0] status_code;
    logic [7:0] received_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [7:0] read_data;
    logic       restarted;
  } out_word_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] kind;
    logic [6:0] held_address;
    logic [7:0] held_byte;
    logic [7:0] captured_byte;
  } seq_state_t;

  function automatic phase_t first_phase(input logic [1:0] kind);
    phase_t ph;
    ph = PH_W_SLA;
    if (kind == FUNC_READ) ph = PH_R_SLA;
    else if (kind == FUNC_REGREAD) ph = PH_G_SLAW;
    return ph;
  endfunction

endpackage
`default_nettype wire

// ===== design/i2c_master_transaction_sequencer.sv =====
// Top level: I2C master transaction sequencer with input and output word registers.
`timescale 1ns / 1ps
`default_nettype none
// Takes one word per cycle while in_ready is high: a request word (write, read
// or register read) or a bus engine status word, and returns exactly one result
// word per input word, in order. An accepted word lands in an input register;
// when the output register is free or being taken, the step logic updates the
// sequencer state and writes the bus command into the output register, which
// drives out_valid and out_data.
// Sustained throughput is one word per clock while out_ready is high, set by the
// single state update path between the two registers; while a finished result
// waits on out_ready, the input register takes one more word, then holds in_ready low.
module i2c_master_transaction_sequencer import i2cts_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output out_word_t out_data
);

  logic       in_valid_r;
  in_word_t   in_word_r;
  logic       out_valid_r;
  out_word_t  out_word_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  out_word_t  res;
  logic       advance;
  logic       fire;

  i2cts_step u_step (
    .st     (state_r),
    .word   (in_word_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  assign advance   = !out_valid_r || out_ready;
  assign fire      = in_valid_r && advance;
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: PH_IDLE, kind: 2'd0, held_address: 7'd0,
                       held_byte: 8'd0, captured_byte: 8'd0};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_data;
    end
    if (fire) begin
      out_word_r <= res;
    end
  end

  a_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.done_res |-> out_word_r.bus_command == CMD_STOP)
    else $error("done without stop");

  a_restart_is_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.restarted |-> out_word_r.bus_command == CMD_START)
    else $error("restart without start");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.done_res |=> state_r.phase == PH_IDLE)
    else $error("phase not idle after done");

  a_read_data_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_word_r.read_data == state_r.captured_byte)
    else $error("read data out of step with captured byte");

endmodule
`default_nettype wire

// ===== design/i2cts_step.sv =====
// Step logic: next sequencer state and bus command for one word.
`timescale 1ns / 1ps
`default_nettype none
module i2cts_step import i2cts_pkg::*; (
  input  seq_state_t st,
  input  in_word_t   word,
  output seq_state_t st_nxt,
  output out_word_t  res
);

  logic       restart;
  logic       start_ok;
  logic       err;
  cmd_t       cmd;
  logic [7:0] tx;
  logic       done;
  logic [7:0] sla_w;
  logic [7:0] sla_r;

  assign start_ok = (word.status_code == ST_START) || (word.status_code == ST_RSTART);
  assign err      = (word.status_code == ST_ARB_LOST) || (word.status_code == ST_BUS_ERR);
  assign sla_w    = {st.held_address, RW_WRITE};
  assign sla_r    = {st.held_address, RW_READ};

  always_comb begin
    st_nxt  = st;
    cmd     = CMD_NONE;
    tx      = 8'd0;
    done    = 1'b0;
    restart = 1'b0;
    if (word.func != FUNC_STATUS) begin
      st_nxt.kind         = word.func;
      st_nxt.held_address = word.target_address;
      st_nxt.held_byte    = word.write_byte;
      st_nxt.phase        = first_phase(word.func);
      cmd                 = CMD_START;
    end else if (st.phase == PH_IDLE || st.phase > PH_G_FIN) begin
      st_nxt.phase = PH_IDLE;
    end else if (err) begin
      restart = 1'b1;
    end else begin
      unique case (st.phase)
        PH_W_SLA, PH_R_SLA, PH_G_SLAW: begin
          if (!start_ok) begin
            restart = 1'b1;
          end else begin
            cmd = CMD_SEND;
            if (st.phase == PH_W_SLA) begin
              tx = sla_w;
              st_nxt.phase = PH_W_DATA;
            end else if (st.phase == PH_R_SLA) begin
              tx = sla_r;
              st_nxt.phase = PH_R_RECV;
            end else begin
              tx = sla_w;
              st_nxt.phase = PH_G_REG;
            end
          end
        end
        PH_W_DATA, PH_G_REG: begin
          if (word.status_code == ST_SLAW_NACK) begin
            restart = 1'b1;
          end else begin
            cmd = CMD_SEND;
            tx  = st.held_byte;
            st_nxt.phase = (st.phase == PH_W_DATA) ? PH_W_FIN : PH_G_RS;
          end
        end
        PH_W_FIN: begin
          if (word.status_code == ST_TXDAT_NACK) begin
            restart = 1'b1;
          end else begin
            cmd  = CMD_STOP;
            done = 1'b1;
            st_nxt.phase = PH_IDLE;
          end
        end
        PH_R_RECV: begin
          if (word.status_code == ST_SLAR_NACK) begin
            restart = 1'b1;
          end else begin
            cmd = CMD_RACK;
            st_nxt.phase = PH_R_FIN;
          end
        end
        PH_R_FIN: begin
          if (word.status_code == ST_RXDAT_NACK) begin
            restart = 1'b1;
          end else begin
            st_nxt.captured_byte = word.received_byte;
            cmd  = CMD_STOP;
            done = 1'b1;
            st_nxt.phase = PH_IDLE;
          end
        end
        PH_G_RS: begin
          cmd = CMD_START;
          st_nxt.phase = PH_G_SLAR;
        end
        PH_G_SLAR: begin
          if (!start_ok) begin
            restart = 1'b1;
          end else begin
            cmd = CMD_SEND;
            tx  = sla_r;
            st_nxt.phase = PH_G_RECV;
          end
        end
        PH_G_RECV: begin
          if (word.status_code == ST_SLAR_NACK) begin
            cmd     = CMD_START;
            restart = 1'b1;
            st_nxt.phase = PH_G_SLAR;
          end else begin
            cmd = CMD_RNACK;
            st_nxt.phase = PH_G_FIN;
          end
        end
        default: begin
          st_nxt.captured_byte = word.received_byte;
          cmd  = CMD_STOP;
          done = 1'b1;
          st_nxt.phase = PH_IDLE;
        end
      endcase
    end
    if (restart && cmd == CMD_NONE) begin
      cmd = CMD_START;
      st_nxt.phase = first_phase(st.kind);
    end
  end

  always_comb begin
    res.bus_command = cmd;
    res.tx_byte     = tx;
    res.done_res    = done;
    res.read_data   = st_nxt.captured_byte;
    res.restarted   = restart;
  end

endmodule
`default_nettype wire

// ===== tb/i2cts_command_checker.sv =====
// Checker: predicts each bus command word of the transaction sequencer and compares it.
`timescale 1ns / 1ps
module i2cts_command_checker import i2cts_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  input  wire       in_ready,
  input  in_word_t  in_data,
  input  wire       out_valid,
  input  wire       out_ready,
  input  out_word_t out_data,
  output int        mismatches,
  output int        pending
);

  phase_t     phase_q;
  logic [1:0] kind_q;
  logic [6:0] addr_q;
  logic [7:0] byte_q;
  logic [7:0] captured_q;

  out_word_t expected_commands[$];
  out_word_t oldest;
  int        error_count = 0;

  function automatic phase_t entry_phase(input logic [1:0] kind);
    phase_t ph;
    case (kind)
      FUNC_READ:    ph = PH_R_SLA;
      FUNC_REGREAD: ph = PH_G_SLAW;
      default:      ph = PH_W_SLA;
    endcase
    return ph;
  endfunction

  function automatic out_word_t predict_command(input in_word_t w);
    out_word_t  r;
    cmd_t       cmd;
    logic [7:0] tx;
    logic       done;
    logic       again;
    logic       start_seen;
    logic [4:0] code;
    code       = w.status_code;
    cmd        = CMD_NONE;
    tx         = 8'h00;
    done       = 1'b0;
    again      = 1'b0;
    start_seen = (code == ST_START) || (code == ST_RSTART);
    if (w.func != FUNC_STATUS) begin
      kind_q  = w.func;
      addr_q  = w.target_address;
      byte_q  = w.write_byte;
      phase_q = entry_phase(w.func);
      cmd     = CMD_START;
    end else if (phase_q != PH_IDLE) begin
      if (code == ST_ARB_LOST || code == ST_BUS_ERR) begin
        again = 1'b1;
      end else begin
        case (phase_q)
          PH_W_SLA: begin
            if (!start_seen) again = 1'b1;
            else begin
              cmd = CMD_SEND; tx = {addr_q, RW_WRITE}; phase_q = PH_W_DATA;
            end
          end
          PH_R_SLA: begin
            if (!start_seen) again = 1'b1;
            else begin
              cmd = CMD_SEND; tx = {addr_q, RW_READ}; phase_q = PH_R_RECV;
            end
          end
          PH_G_SLAW: begin
            if (!start_seen) again = 1'b1;
            else begin
              cmd = CMD_SEND; tx = {addr_q, RW_WRITE}; phase_q = PH_G_REG;
            end
          end
          PH_W_DATA: begin
            if (code == ST_SLAW_NACK) again = 1'b1;
            else begin
              cmd = CMD_SEND; tx = byte_q; phase_q = PH_W_FIN;
            end
          end
          PH_G_REG: begin
            if (code == ST_SLAW_NACK) again = 1'b1;
            else begin
              cmd = CMD_SEND; tx = byte_q; phase_q = PH_G_RS;
            end
          end
          PH_W_FIN: begin
            if (code == ST_TXDAT_NACK) again = 1'b1;
            else begin
              cmd = CMD_STOP; done = 1'b1; phase_q = PH_IDLE;
            end
          end
          PH_R_RECV: begin
            if (code == ST_SLAR_NACK) again = 1'b1;
            else begin
              cmd = CMD_RACK; phase_q = PH_R_FIN;
            end
          end
          PH_R_FIN: begin
            if (code == ST_RXDAT_NACK) again = 1'b1;
            else begin
              captured_q = w.received_byte;
              cmd = CMD_STOP; done = 1'b1; phase_q = PH_IDLE;
            end
          end
          PH_G_RS: begin
            cmd = CMD_START; phase_q = PH_G_SLAR;
          end
          PH_G_SLAR: begin
            if (!start_seen) again = 1'b1;
            else begin
              cmd = CMD_SEND; tx = {addr_q, RW_READ}; phase_q = PH_G_RECV;
            end
          end
          PH_G_RECV: begin
            if (code == ST_SLAR_NACK) begin
              cmd = CMD_START; phase_q = PH_G_SLAR; again = 1'b1;
            end else begin
              cmd = CMD_RNACK; phase_q = PH_G_FIN;
            end
          end
          PH_G_FIN: begin
            captured_q = w.received_byte;
            cmd = CMD_STOP; done = 1'b1; phase_q = PH_IDLE;
          end
          default: phase_q = PH_IDLE;
        endcase
      end
      if (again && cmd == CMD_NONE) begin
        cmd     = CMD_START;
        phase_q = entry_phase(kind_q);
      end
    end
    r.bus_command = cmd;
    r.tx_byte     = tx;
    r.done_res    = done;
    r.read_data   = captured_q;
    r.restarted   = again;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      phase_q    = PH_IDLE;
      kind_q     = 2'b00;
      addr_q     = 7'h00;
      byte_q     = 8'h00;
      captured_q = 8'h00;
      expected_commands.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_commands.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected word: cmd=%0d tx=%h done=%b data=%h restart=%b",
                     out_data.bus_command, out_data.tx_byte, out_data.done_res,
                     out_data.read_data, out_data.restarted);
        end else begin
          oldest = expected_commands.pop_front();
          if (out_data.bus_command !== oldest.bus_command ||
              out_data.tx_byte !== oldest.tx_byte ||
              out_data.done_res !== oldest.done_res ||
              out_data.read_data !== oldest.read_data ||
              out_data.restarted !== oldest.restarted) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: expected cmd=%0d tx=%h done=%b data=%h restart=%b, %s",
                       oldest.bus_command, oldest.tx_byte, oldest.done_res,
                       oldest.read_data, oldest.restarted,
                       $sformatf("got cmd=%0d tx=%h done=%b data=%h restart=%b",
                                 out_data.bus_command, out_data.tx_byte,
                                 out_data.done_res, out_data.read_data,
                                 out_data.restarted));
          end
        end
      end
      if (in_valid && in_ready)
        expected_commands.push_back(predict_command(in_data));
    end
    mismatches <= error_count;
    pending    <= expected_commands.size();
  end

endmodule

// ===== tb/tb_i2c_master_transaction_sequencer.sv =====
// Testbench top: drives request and status words into the sequencer and gives the verdict.
`timescale 1ns / 1ps
module tb_i2c_master_transaction_sequencer;
  import i2cts_pkg::*;

  localparam logic [4:0] ST_SLAW_ACK  = 5'd3;   // 0x18
  localparam logic [4:0] ST_TXDAT_ACK = 5'd5;   // 0x28
  localparam logic [4:0] ST_SLAR_ACK  = 5'd8;   // 0x40
  localparam logic [4:0] ST_RXDAT_ACK = 5'd10;  // 0x50
  localparam int TOTAL_WORDS = 1650;
  localparam int LONG_STALL  = 200;
  localparam int CYCLE_LIMIT = 500000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  int          mismatches;
  int          pending;
  int          words_sent = 0;
  int          stall_requests = 0;
  int          stalls_done = 0;
  logic        burst = 1'b0;
  int unsigned cycle_count = 0;

  i2c_master_transaction_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  i2cts_command_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap(input logic no_gaps);
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic in_word_t make_word(input logic [1:0] func, input logic [6:0] addr,
                                         input logic [7:0] wbyte, input logic [4:0] code,
                                         input logic [7:0] rbyte);
    in_word_t w;
    w.func           = func;
    w.target_address = addr;
    w.write_byte     = wbyte;
    w.status_code    = code;
    w.received_byte  = rbyte;
    return w;
  endfunction

  function automatic in_word_t status_word(input logic [4:0] code);
    return make_word(FUNC_STATUS, 7'($urandom), 8'($urandom), code, 8'($urandom));
  endfunction

  function automatic logic [4:0] good_status(input logic [1:0] kind, input int idx);
    logic [4:0] code;
    case (idx)
      0: code = $urandom_range(0, 1) ? ST_START : ST_RSTART;
      1: code = (kind == FUNC_READ) ? ST_SLAR_ACK : ST_SLAW_ACK;
      2: code = (kind == FUNC_READ) ? ST_RXDAT_ACK : ST_TXDAT_ACK;
      3: code = ST_RSTART;
      4: code = ST_SLAR_ACK;
      default: code = ST_RXDAT_NACK;
    endcase
    return code;
  endfunction

  task automatic issue_word(input in_word_t w, input bit counted);
    int gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (counted) words_sent++;
  endtask

  task automatic run_transaction(input logic [1:0] kind);
    int         steps;
    int         idx;
    int         tries;
    int         r;
    logic [4:0] code;
    steps = (kind == FUNC_REGREAD) ? 6 : 3;
    idx   = 0;
    tries = 0;
    issue_word(make_word(kind, 7'($urandom), 8'($urandom), 5'($urandom), 8'($urandom)),
               1'b1);
    while (idx < steps) begin
      if ($urandom_range(0, 99) < 3) return;
      if ($urandom_range(0, 99) < 7) begin
        r = $urandom_range(0, 99);
        if (r < 25) code = ST_ARB_LOST;
        else if (r < 40) code = ST_BUS_ERR;
        else if (r < 50) code = ST_SLAW_NACK;
        else if (r < 60) code = ST_TXDAT_NACK;
        else if (r < 70) code = ST_SLAR_NACK;
        else if (r < 80) code = ST_RXDAT_NACK;
        else code = 5'($urandom_range(0, 31));
        issue_word(status_word(code), 1'b1);
        tries++;
        if (tries > 3) return;
        // SLA+R NACK in a register read only repeats the read address
        if (kind == FUNC_REGREAD && idx == 4 && code == ST_SLAR_NACK) idx = 3;
        else idx = 0;
      end else begin
        issue_word(status_word(good_status(kind, idx)), 1'b1);
        idx++;
      end
    end
  endtask

  initial begin
    int         r;
    bit         stall_asked;
    bit         drained;
    logic [1:0] func;
    stall_asked = 1'b0;
    drained     = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_BUS_ERR, 8'hFF), 1'b0);
    issue_word(make_word(FUNC_STATUS, 7'h7F, 8'hFF, 5'h1F, 8'h00), 1'b0);
    issue_word(make_word(FUNC_WRITE, 7'h7F, 8'hFF, 5'h1F, 8'hFF), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_START, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_SLAW_ACK, 8'hFF), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h7F, 8'hFF, ST_TXDAT_ACK, 8'h3C), 1'b1);
    issue_word(make_word(FUNC_READ, 7'h00, 8'h00, ST_BUS_ERR, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_RSTART, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_SLAR_ACK, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_RXDAT_NACK, 8'h77), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_ARB_LOST, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_START, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_SLAR_ACK, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_RXDAT_ACK, 8'hA5), 1'b1);
    issue_word(make_word(FUNC_REGREAD, 7'h55, 8'h00, ST_BUS_ERR, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h2A, 8'hAA, ST_START, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_SLAW_ACK, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, 5'h1F, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_RSTART, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_SLAR_NACK, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_BUS_ERR, 8'h00), 1'b1);
    issue_word(make_word(FUNC_WRITE, 7'h01, 8'h01, ST_BUS_ERR, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_START, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_SLAW_NACK, 8'h00), 1'b1);
    issue_word(make_word(FUNC_STATUS, 7'h00, 8'h00, ST_TXDAT_NACK, 8'h00), 1'b1);

    while (words_sent < TOTAL_WORDS) begin
      burst = ($urandom_range(0, 4) == 0);
      if (!stall_asked && words_sent >= 500) begin
        stall_requests++;
        stall_asked = 1'b1;
      end
      if (!drained && words_sent >= 1000) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 88) begin
        run_transaction(2'($urandom_range(0, 2)));
      end else begin
        func = 2'($urandom_range(0, 3));
        issue_word(make_word(func, 7'($urandom), 8'($urandom), 5'($urandom),
                             8'($urandom)),
                   func != FUNC_STATUS);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int gap;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (stalls_done != stall_requests) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stalls_done++;
      end else begin
        gap = pick_gap($urandom_range(0, 4) == 0);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

endmodule
